// File: design/pea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pea_pkg
// Shared widths, constants and stage payload types of the peak-envelope
// amplitude compressor.
// ----------------------------------------------------------------------------
package pea_pkg;

  // sample format
  localparam int SAMPLE_WIDTH = 16;
  localparam int TDATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

  // magnitude path
  localparam int POWER_W = 2 * SAMPLE_WIDTH;
  localparam int MAG_W   = SAMPLE_WIDTH;
  localparam int REM_W   = SAMPLE_WIDTH + 3;

  // two result bits resolved per pipeline stage
  localparam int STEPS       = 2;
  localparam int SQRT_STAGES = (SAMPLE_WIDTH + STEPS - 1) / STEPS;
  localparam int DIV_STAGES  = (SAMPLE_WIDTH + STEPS - 1) / STEPS;

  // gain path, Q4.16
  localparam int                 SCALE_W    = 19;
  localparam logic [SCALE_W-1:0] GAIN_SCALE = SCALE_W'(370728);
  localparam int                 PROD_W     = MAG_W + SCALE_W;
  localparam int                 GAIN_W     = PROD_W - SAMPLE_WIDTH + 1;
  localparam int                 UNITY_SHIFT = 16;
  localparam logic [GAIN_W-1:0]  UNITY_Q16  = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0]  UNITY_X2   = GAIN_W'(131072);
  localparam int                 NUM_W      = SAMPLE_WIDTH + UNITY_SHIFT;
  localparam int                 DREM_W     = GAIN_W + 1;

  // lane codes
  localparam int LANE_I = 0;
  localparam int LANE_Q = 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [MAG_W-1:0]               mag_t;
  typedef logic [SAMPLE_WIDTH-1:0]        umag_t;

  typedef struct packed {
    sample_t            re;
    sample_t            im;
    logic [POWER_W-1:0] power;
  } sq_in_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
    mag_t    mag;
  } sq_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    umag_t [1:0]       absval;
    logic [1:0]        neg;
  } div_in_t;

  typedef struct packed {
    umag_t [1:0] quo;
    logic [1:0]  neg;
  } div_out_t;

endpackage

// File: design/pea_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pea_sqrt
// Pipelined integer square root, two root bits per stage, with the sample
// carried alongside. Stages collapse bubbles.
// ----------------------------------------------------------------------------
module pea_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pea_pkg::sq_in_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pea_pkg::sq_out_t out_data_o
);
  import pea_pkg::*;

  localparam int Last = SQRT_STAGES - 1;

  typedef struct packed {
    logic [POWER_W-1:0] x;
    mag_t               root;
    logic [REM_W-1:0]   rem;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_stage(sqrt_st_t st_in, int s);
    sqrt_st_t         st;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    st = st_in;
    for (int j = 0; j < STEPS; j++) begin
      if (s * STEPS + j < SAMPLE_WIDTH) begin
        rem_sh = {st.rem[REM_W-3:0], st.x[POWER_W-1 -: 2]};
        trial  = REM_W'({st.root, 2'b01});
        st.x   = st.x << 2;
        if (rem_sh >= trial) begin
          st.rem  = rem_sh - trial;
          st.root = {st.root[MAG_W-2:0], 1'b1};
        end else begin
          st.rem  = rem_sh;
          st.root = {st.root[MAG_W-2:0], 1'b0};
        end
      end
    end
    return st;
  endfunction

  logic     valid_q [SQRT_STAGES];
  logic     adv     [SQRT_STAGES];
  sqrt_st_t st_q    [SQRT_STAGES];
  sqrt_st_t st_d    [SQRT_STAGES];
  sample_t  re_q    [SQRT_STAGES];
  sample_t  im_q    [SQRT_STAGES];

  // a stage loads when empty or when its item moves on
  always_comb begin
    adv[Last] = !valid_q[Last] || out_ready_i;
    for (int s = Last - 1; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  always_comb begin
    sqrt_st_t st0;
    st0.x    = in_data_i.power;
    st0.root = '0;
    st0.rem  = '0;
    st_d[0]  = sqrt_stage(st0, 0);
    for (int s = 1; s < SQRT_STAGES; s++) begin
      st_d[s] = sqrt_stage(st_q[s-1], s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      for (int s = 1; s < SQRT_STAGES; s++) begin
        if (adv[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      st_q[0] <= st_d[0];
      re_q[0] <= in_data_i.re;
      im_q[0] <= in_data_i.im;
    end
    for (int s = 1; s < SQRT_STAGES; s++) begin
      if (adv[s] && valid_q[s-1]) begin
        st_q[s] <= st_d[s];
        re_q[s] <= re_q[s-1];
        im_q[s] <= im_q[s-1];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[Last];

  always_comb begin
    out_data_o.re  = re_q[Last];
    out_data_o.im  = im_q[Last];
    out_data_o.mag = st_q[Last].root;
  end

endmodule

// File: design/pea_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pea_div
// Two-lane pipelined restoring divider: |component| * 2^16 / gain, two
// quotient bits per stage. Stages collapse bubbles.
// ----------------------------------------------------------------------------
module pea_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pea_pkg::div_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pea_pkg::div_out_t out_data_o
);
  import pea_pkg::*;

  localparam int Last = DIV_STAGES - 1;

  typedef struct packed {
    logic [GAIN_W-1:0]       gain;
    logic [1:0][DREM_W-1:0]  r;
    umag_t [1:0]             n;
    umag_t [1:0]             quo;
    logic [1:0]              neg;
  } div_st_t;

  function automatic div_st_t div_stage(div_st_t st_in, int s);
    div_st_t           st;
    logic [DREM_W-1:0] r_sh;
    st = st_in;
    for (int j = 0; j < STEPS; j++) begin
      if (s * STEPS + j < SAMPLE_WIDTH) begin
        for (int l = 0; l < 2; l++) begin
          r_sh    = {st.r[l][DREM_W-2:0], st.n[l][SAMPLE_WIDTH-1]};
          st.n[l] = st.n[l] << 1;
          if (r_sh >= DREM_W'(st.gain)) begin
            st.r[l]   = r_sh - DREM_W'(st.gain);
            st.quo[l] = {st.quo[l][SAMPLE_WIDTH-2:0], 1'b1};
          end else begin
            st.r[l]   = r_sh;
            st.quo[l] = {st.quo[l][SAMPLE_WIDTH-2:0], 1'b0};
          end
        end
      end
    end
    return st;
  endfunction

  logic    valid_q [DIV_STAGES];
  logic    adv     [DIV_STAGES];
  div_st_t st_q    [DIV_STAGES];
  div_st_t st_d    [DIV_STAGES];

  always_comb begin
    adv[Last] = !valid_q[Last] || out_ready_i;
    for (int s = Last - 1; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  // the quotient fits SAMPLE_WIDTH bits, so the numerator bits above that
  // seed the remainder directly (always below the gain)
  always_comb begin
    div_st_t          st0;
    logic [NUM_W-1:0] num;
    st0.gain = in_data_i.gain;
    st0.neg  = in_data_i.neg;
    st0.quo  = '0;
    for (int l = 0; l < 2; l++) begin
      num       = {in_data_i.absval[l], UNITY_SHIFT'(0)};
      st0.r[l]  = DREM_W'(num[NUM_W-1 -: UNITY_SHIFT]);
      st0.n[l]  = num[SAMPLE_WIDTH-1:0];
    end
    st_d[0] = div_stage(st0, 0);
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_d[s] = div_stage(st_q[s-1], s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      for (int s = 1; s < DIV_STAGES; s++) begin
        if (adv[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) st_q[0] <= st_d[0];
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (adv[s] && valid_q[s-1]) st_q[s] <= st_d[s];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[Last];

  always_comb begin
    out_data_o.quo = st_q[Last].quo;
    out_data_o.neg = st_q[Last].neg;
  end

endmodule

// File: design/peak_envelope_amplitude_compressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_envelope_amplitude_compressor
// Peak-envelope amplitude compressor for a complex I/Q sample stream.
//
// Takes one I/Q item per clock cycle, sustained while m_axis_tready holds
// high. Each result passes through the square-root and divider pipelines,
// each resolving two result bits per stage over SAMPLE_WIDTH bits, plus
// seven single-stage steps. The block forms floor(sqrt(I^2+Q^2)) per item,
// takes the peak over the last five magnitudes, derives a Q4.16 gain
// max(1, 8*sqrt(2)*peak - 1) and emits the item from two items earlier
// divided by that gain, rounded toward zero. The first two items after
// reset give no result; the magnitude history starts at zero. Every stage
// holds its own valid bit and loads when empty, so the input side keeps
// taking items while a result waits, until every stage is full.
// ----------------------------------------------------------------------------
module peak_envelope_amplitude_compressor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [15:0] sample_i, [31:16] sample_q
  input  logic [pea_pkg::TDATA_W-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [15:0] out_i, [31:16] out_q
  output logic [pea_pkg::TDATA_W-1:0] m_axis_tdata
);
  import pea_pkg::*;

  localparam logic [1:0] PrimeFull = 2'd2;

  function automatic mag_t mag_max(mag_t a, mag_t b);
    return (a > b) ? a : b;
  endfunction

  // --------------------------------------------------------------------------
  // stage in: input register
  // --------------------------------------------------------------------------
  logic    in_valid_q;
  sample_t in_re_q, in_im_q;
  logic    adv_in, adv_sqr, adv_pow, adv_win, adv_mul, adv_gain, adv_out;

  assign adv_in        = !in_valid_q || adv_sqr;
  assign s_axis_tready = adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv_in) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && s_axis_tvalid) begin
      in_re_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
      in_im_q <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    end
  end

  // --------------------------------------------------------------------------
  // stage sqr: component squares
  // --------------------------------------------------------------------------
  logic                      sqr_valid_q;
  sample_t                   sqr_re_q, sqr_im_q;
  logic [POWER_W-1:0]        sqr_pre_q, sqr_pim_q;
  logic signed [POWER_W-1:0] sqr_re_d, sqr_im_d;

  assign adv_sqr  = !sqr_valid_q || adv_pow;
  assign sqr_re_d = in_re_q * in_re_q;
  assign sqr_im_d = in_im_q * in_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqr_valid_q <= 1'b0;
    end else if (adv_sqr) begin
      sqr_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_sqr && in_valid_q) begin
      sqr_re_q  <= in_re_q;
      sqr_im_q  <= in_im_q;
      sqr_pre_q <= unsigned'(sqr_re_d);
      sqr_pim_q <= unsigned'(sqr_im_d);
    end
  end

  // --------------------------------------------------------------------------
  // stage pow: power, feeds the root pipeline
  // --------------------------------------------------------------------------
  logic               pow_valid_q;
  sample_t            pow_re_q, pow_im_q;
  logic [POWER_W-1:0] pow_q;
  logic               sqrt_in_ready;
  sq_in_t             sqrt_in;

  assign adv_pow = !pow_valid_q || sqrt_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow_valid_q <= 1'b0;
    end else if (adv_pow) begin
      pow_valid_q <= sqr_valid_q;
    end
  end

  // squares are each at most 2^(2w-2), so the sum cannot carry out
  always_ff @(posedge clk_i) begin
    if (adv_pow && sqr_valid_q) begin
      pow_re_q <= sqr_re_q;
      pow_im_q <= sqr_im_q;
      pow_q    <= sqr_pre_q + sqr_pim_q;
    end
  end

  always_comb begin
    sqrt_in.re    = pow_re_q;
    sqrt_in.im    = pow_im_q;
    sqrt_in.power = pow_q;
  end

  logic    sqrt_out_valid;
  sq_out_t sqrt_out;

  pea_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pow_valid_q),
    .in_ready_o  (sqrt_in_ready),
    .in_data_i   (sqrt_in),
    .out_valid_o (sqrt_out_valid),
    .out_ready_i (adv_win),
    .out_data_o  (sqrt_out)
  );

  // --------------------------------------------------------------------------
  // stage win: magnitude window, sample delay line, start-up count
  // Window state moves only when a magnitude actually enters; the first two
  // items fill the delay line and leave as bubbles.
  // --------------------------------------------------------------------------
  logic       win_valid_q;
  mag_t       win_peak_q;
  sample_t    win_re_q, win_im_q;
  mag_t       hist_q   [4];
  sample_t    dly_re_q [2];
  sample_t    dly_im_q [2];
  logic [1:0] prime_q;
  logic       win_take;
  mag_t       win_peak_d;

  assign adv_win  = !win_valid_q || adv_mul;
  assign win_take = sqrt_out_valid && adv_win;

  // peak over four held magnitudes and the newest one
  always_comb begin
    win_peak_d = mag_max(mag_max(mag_max(hist_q[0], hist_q[1]),
                                 mag_max(hist_q[2], hist_q[3])),
                         sqrt_out.mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
      prime_q     <= '0;
      for (int k = 0; k < 4; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (adv_win) win_valid_q <= win_take && (prime_q == PrimeFull);
      if (win_take) begin
        if (prime_q != PrimeFull) prime_q <= prime_q + 2'd1;
        for (int k = 0; k < 3; k++) begin
          hist_q[k] <= hist_q[k+1];
        end
        hist_q[3] <= sqrt_out.mag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_take) begin
      win_peak_q  <= win_peak_d;
      win_re_q    <= dly_re_q[0];
      win_im_q    <= dly_im_q[0];
      dly_re_q[0] <= dly_re_q[1];
      dly_im_q[0] <= dly_im_q[1];
      dly_re_q[1] <= sqrt_out.re;
      dly_im_q[1] <= sqrt_out.im;
    end
  end

  // --------------------------------------------------------------------------
  // stage mul: peak times gain scale; split components into sign and size
  // --------------------------------------------------------------------------
  logic              mul_valid_q;
  logic [PROD_W-1:0] mul_prod_q;
  umag_t [1:0]       mul_abs_q;
  logic [1:0]        mul_neg_q;

  assign adv_mul = !mul_valid_q || adv_gain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (adv_mul) begin
      mul_valid_q <= win_valid_q;
    end
  end

  // the most negative value maps to 2^(w-1), which the unsigned size holds
  always_ff @(posedge clk_i) begin
    if (adv_mul && win_valid_q) begin
      mul_prod_q        <= PROD_W'(win_peak_q) * PROD_W'(GAIN_SCALE);
      mul_neg_q[LANE_I] <= win_re_q[SAMPLE_WIDTH-1];
      mul_neg_q[LANE_Q] <= win_im_q[SAMPLE_WIDTH-1];
      mul_abs_q[LANE_I] <= win_re_q[SAMPLE_WIDTH-1] ? unsigned'(-win_re_q)
                                                    : unsigned'(win_re_q);
      mul_abs_q[LANE_Q] <= win_im_q[SAMPLE_WIDTH-1] ? unsigned'(-win_im_q)
                                                    : unsigned'(win_im_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage gain: Q4.16 gain, clamped at unity
  // --------------------------------------------------------------------------
  logic              gain_valid_q;
  logic [GAIN_W-1:0] gain_q, gain_t, gain_d;
  umag_t [1:0]       gain_abs_q;
  logic [1:0]        gain_neg_q;
  logic              div_in_ready;
  div_in_t           div_in;

  assign adv_gain = !gain_valid_q || div_in_ready;
  assign gain_t   = mul_prod_q[PROD_W-1:SAMPLE_WIDTH-1];
  assign gain_d   = (gain_t >= UNITY_X2) ? (gain_t - UNITY_Q16) : UNITY_Q16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_valid_q <= 1'b0;
    end else if (adv_gain) begin
      gain_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_gain && mul_valid_q) begin
      gain_q     <= gain_d;
      gain_abs_q <= mul_abs_q;
      gain_neg_q <= mul_neg_q;
    end
  end

  always_comb begin
    div_in.gain   = gain_q;
    div_in.absval = gain_abs_q;
    div_in.neg    = gain_neg_q;
  end

  logic     div_out_valid;
  div_out_t div_out;

  pea_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (gain_valid_q),
    .in_ready_o  (div_in_ready),
    .in_data_i   (div_in),
    .out_valid_o (div_out_valid),
    .out_ready_i (adv_out),
    .out_data_o  (div_out)
  );

  // --------------------------------------------------------------------------
  // stage out: restore sign, output register
  // --------------------------------------------------------------------------
  logic    out_valid_q;
  sample_t out_re_q, out_im_q;

  assign adv_out = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && div_out_valid) begin
      out_re_q <= div_out.neg[LANE_I] ? signed'(-div_out.quo[LANE_I])
                                      : signed'(div_out.quo[LANE_I]);
      out_im_q <= div_out.neg[LANE_Q] ? signed'(-div_out.quo[LANE_Q])
                                      : signed'(div_out.quo[LANE_Q]);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'({out_im_q, out_re_q});

endmodule

// File: design/pea_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pea_checker
// Port-level checks of the compressor: output handshake and item counts
// against the start-up rule.
// ----------------------------------------------------------------------------
module pea_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [pea_pkg::TDATA_W-1:0] m_axis_tdata
);
  import pea_pkg::*;

  localparam int CreditW = $clog2(SQRT_STAGES + DIV_STAGES + 8) + 1;

  logic [1:0]         seen_q;
  logic [CreditW-1:0] credit_q;
  logic               in_acc, out_acc, earn;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign earn    = in_acc && (seen_q >= 2'd2);

  // items seen (saturating) and results still owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      credit_q <= '0;
    end else begin
      if (in_acc && (seen_q != 2'd3)) seen_q <= seen_q + 2'd1;
      credit_q <= credit_q + CreditW'(earn) - CreditW'(out_acc);
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_startup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seen_q == 2'd3)
    else $error("result before the third item");

  a_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> credit_q != '0)
    else $error("result without a matching item");

endmodule

bind peak_envelope_amplitude_compressor pea_checker u_pea_checker (.*);
